// ===== rtl/core/owms_pkg.sv =====
package owms_pkg;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int ACTION_W  = 3;
    localparam int BYTE_W    = 8;
    localparam int BITS_W    = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK       = 3'd0,
        ACT_RESET_LOW  = 3'd1,
        ACT_PRESENCE   = 3'd2,
        ACT_WRITE_BYTE = 3'd3,
        ACT_READ_BYTE  = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ONE_LOW     = 3'd0,
        REG_ONE_REL     = 3'd1,
        REG_ZERO_LOW    = 3'd2,
        REG_ZERO_REL    = 3'd3,
        REG_READ_SAMPLE = 3'd4,
        REG_RESET       = 3'd5,
        REG_PRES_SAMPLE = 3'd6
    } cfg_index_t;

    localparam logic [CFG_W-1:0] ONE_LOW_RST     = 10'd10;
    localparam logic [CFG_W-1:0] ONE_REL_RST     = 10'd85;
    localparam logic [CFG_W-1:0] ZERO_LOW_RST    = 10'd80;
    localparam logic [CFG_W-1:0] ZERO_REL_RST    = 10'd15;
    localparam logic [CFG_W-1:0] READ_SAMPLE_RST = 10'd10;
    localparam logic [CFG_W-1:0] RESET_TIME_RST  = 10'd500;
    localparam logic [CFG_W-1:0] PRES_SAMPLE_RST = 10'd50;

    localparam logic [BYTE_W-1:0] SAMPLE_SET_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] READ_FILL       = 8'hFF;
    localparam logic [BITS_W-1:0] BYTE_BITS       = 4'd8;

    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        logic              done_res;
        logic              busy_res;
        logic              drive_low;
    } result_t;

endpackage

// ===== rtl/core/one_wire_master_slot_timer.sv =====
// Results are registered: each shows on m_tdata the cycle after its transfer.
// Throughput: one transfer per cycle; the phase counter, its compare and the
// shift register all update in a single pass, and the output register keeps
// accepting while m_tready is high or the output is empty.
// Reset: synchronous active-low aresetn; bus released, idle, settings to defaults.
module one_wire_master_slot_timer #(
    parameter int TIMER_BITS = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] write_value, [8] line_level, [15:9] zero
    input  logic [15:0]                   s_tdata,
    // [2:0] action
    input  logic [owms_pkg::ACTION_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [10:3] result_byte, [15:11] zero
    output logic [15:0]                   m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [owms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [owms_pkg::CFG_W-1:0]    cfg_data
);
    import owms_pkg::*;

    logic [CFG_W-1:0] one_low_reg, one_rel_reg, zero_low_reg, zero_rel_reg;
    logic [CFG_W-1:0] read_sample_reg, reset_time_reg, pres_sample_reg;

    logic [TIMER_BITS-1:0] phase_timer_reg, phase_timer_next;
    logic [TIMER_BITS-1:0] phase_length_reg, phase_length_next;
    logic [TIMER_BITS-1:0] sample_point_reg, sample_point_next;
    logic                  pulling_low_reg, pulling_low_next;
    logic [BITS_W-1:0]     bits_left_reg, bits_left_next;
    logic [BYTE_W-1:0]     shift_byte_reg, shift_byte_next;
    logic                  active_reg, active_next;
    logic                  sample_enable_reg, sample_enable_next;

    result_t               result_reg, result_next;
    logic                  out_valid_reg;

    logic                  in_xfer;
    logic [BYTE_W-1:0]     write_value;
    logic                  line_level;
    logic [TIMER_BITS-1:0] timer_inc;
    logic [BYTE_W-1:0]     sampled_byte;
    logic                  done;

    assign write_value = s_tdata[7:0];
    assign line_level  = s_tdata[8];
    assign s_tready    = !out_valid_reg || m_tready;
    assign in_xfer     = s_tvalid && s_tready;
    assign cfg_ready   = 1'b1;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = {5'd0, result_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_low_reg     <= ONE_LOW_RST;
            one_rel_reg     <= ONE_REL_RST;
            zero_low_reg    <= ZERO_LOW_RST;
            zero_rel_reg    <= ZERO_REL_RST;
            read_sample_reg <= READ_SAMPLE_RST;
            reset_time_reg  <= RESET_TIME_RST;
            pres_sample_reg <= PRES_SAMPLE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ONE_LOW:     one_low_reg     <= cfg_data;
                REG_ONE_REL:     one_rel_reg     <= cfg_data;
                REG_ZERO_LOW:    zero_low_reg    <= cfg_data;
                REG_ZERO_REL:    zero_rel_reg    <= cfg_data;
                REG_READ_SAMPLE: read_sample_reg <= cfg_data;
                REG_RESET:       reset_time_reg  <= cfg_data;
                REG_PRES_SAMPLE: pres_sample_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        phase_timer_next   = phase_timer_reg;
        phase_length_next  = phase_length_reg;
        sample_point_next  = sample_point_reg;
        pulling_low_next   = pulling_low_reg;
        bits_left_next     = bits_left_reg;
        shift_byte_next    = shift_byte_reg;
        active_next        = active_reg;
        sample_enable_next = sample_enable_reg;
        done               = 1'b0;

        timer_inc    = phase_timer_reg + TIMER_BITS'(1);
        sampled_byte = shift_byte_reg;
        if (sample_enable_reg && !pulling_low_reg && timer_inc == sample_point_reg
            && line_level) begin
            sampled_byte = shift_byte_reg | SAMPLE_SET_MASK;
        end

        case (s_tuser) inside
            ACT_RESET_LOW, ACT_PRESENCE, ACT_WRITE_BYTE, ACT_READ_BYTE: begin
                if (!active_reg) begin
                    phase_timer_next   = '0;
                    active_next        = 1'b1;
                    pulling_low_next   = 1'b0;
                    sample_enable_next = 1'b0;
                    sample_point_next  = '0;
                    bits_left_next     = BYTE_BITS;
                    phase_length_next  = TIMER_BITS'(one_low_reg);
                    case (s_tuser)
                        ACT_RESET_LOW: begin
                            phase_length_next = TIMER_BITS'(reset_time_reg);
                            pulling_low_next  = 1'b1;
                            bits_left_next    = '0;
                            shift_byte_next   = '0;
                        end
                        ACT_PRESENCE: begin
                            phase_length_next  = TIMER_BITS'(reset_time_reg);
                            bits_left_next     = '0;
                            shift_byte_next    = '0;
                            sample_enable_next = 1'b1;
                            sample_point_next  = TIMER_BITS'(pres_sample_reg);
                        end
                        ACT_WRITE_BYTE: begin
                            shift_byte_next = write_value;
                        end
                        default: begin
                            shift_byte_next    = READ_FILL;
                            sample_enable_next = 1'b1;
                            sample_point_next  = TIMER_BITS'(read_sample_reg);
                        end
                    endcase
                end
            end
            default: begin
                if (active_reg) begin
                    phase_timer_next = timer_inc;
                    shift_byte_next  = sampled_byte;
                    if (timer_inc >= phase_length_reg) begin
                        phase_timer_next = '0;
                        if (bits_left_reg == '0) begin
                            active_next = 1'b0;
                            done        = 1'b1;
                        end else if (pulling_low_reg) begin
                            pulling_low_next  = 1'b0;
                            phase_length_next = sampled_byte[0] ?
                                TIMER_BITS'(one_rel_reg) : TIMER_BITS'(zero_rel_reg);
                            bits_left_next    = bits_left_reg - BITS_W'(1);
                            shift_byte_next   = sampled_byte >> 1;
                        end else begin
                            pulling_low_next  = 1'b1;
                            phase_length_next = sampled_byte[0] ?
                                TIMER_BITS'(one_low_reg) : TIMER_BITS'(zero_low_reg);
                        end
                    end
                end
            end
        endcase

        result_next.drive_low   = pulling_low_next;
        result_next.busy_res    = active_next;
        result_next.done_res    = done;
        result_next.result_byte = shift_byte_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_timer_reg   <= '0;
            phase_length_reg  <= '0;
            sample_point_reg  <= '0;
            pulling_low_reg   <= 1'b0;
            bits_left_reg     <= '0;
            shift_byte_reg    <= '0;
            active_reg        <= 1'b0;
            sample_enable_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (in_xfer) begin
                phase_timer_reg   <= phase_timer_next;
                phase_length_reg  <= phase_length_next;
                sample_point_reg  <= sample_point_next;
                pulling_low_reg   <= pulling_low_next;
                bits_left_reg     <= bits_left_next;
                shift_byte_reg    <= shift_byte_next;
                active_reg        <= active_next;
                sample_enable_reg <= sample_enable_next;
                out_valid_reg     <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && result_reg.done_res |-> !result_reg.busy_res)
        else $error("done reported while still busy");

    a_idle_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> phase_timer_reg == '0)
        else $error("phase timer running while idle");

    a_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_left_reg <= BYTE_BITS)
        else $error("bit counter out of range");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> m_tvalid && result_reg.busy_res == active_reg
            && result_reg.result_byte == shift_byte_reg)
        else $error("result does not match updated state");
`endif

endmodule
